// File: sv/dnq_pkg.sv
// Shared constants and types for the DNS query name extractor.
`default_nettype none
package dnq_pkg;

	localparam int BUFFER_BYTES = 512;
	localparam int POS_W        = $clog2(BUFFER_BYTES + 1);

	localparam logic [POS_W-1:0] BUF_LIMIT = POS_W'(BUFFER_BYTES);
	localparam logic [POS_W-1:0] HDR_BYTES = POS_W'(12);
	localparam logic [POS_W-1:0] POS_FLAGS = POS_W'(2);
	localparam logic [POS_W-1:0] POS_QDHI  = POS_W'(4);
	localparam logic [POS_W-1:0] POS_QDLO  = POS_W'(5);
	localparam logic [POS_W-1:0] POS_HLAST = POS_W'(11);

	localparam logic [7:0] MAX_LABEL = 8'd63;
	localparam logic [8:0] LEN_MAX   = 9'd511;
	localparam logic [7:0] DOT_CHAR  = 8'd46;

	localparam logic [2:0] V_OK       = 3'd0;
	localparam logic [2:0] V_SHORT    = 3'd1;
	localparam logic [2:0] V_NOTSTD   = 3'd2;
	localparam logic [2:0] V_NOQ      = 3'd3;
	localparam logic [2:0] V_BADLABEL = 3'd4;
	localparam logic [2:0] V_EMPTY    = 3'd5;

	localparam logic RK_CHAR    = 1'b0;
	localparam logic RK_VERDICT = 1'b1;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [3:0] {
		PH_HEADER = 4'b0001,
		PH_LENGTH = 4'b0010,
		PH_LABEL  = 4'b0100,
		PH_DONE   = 4'b1000
	} phase_t;

	typedef struct packed {
		logic       result_kind;
		logic [7:0] name_char;
		logic [2:0] verdict;
		logic [8:0] name_length;
		logic       end_of_run;
	} result_t;

endpackage
`default_nettype wire

// File: sv/dnq_if.sv
// Valid/ready channel interfaces for packet bytes and extracted results.
`default_nettype none
interface dnq_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dnq_result_if;
	logic       valid;
	logic       ready;
	logic       result_kind;
	logic [7:0] name_char;
	logic [2:0] verdict;
	logic [8:0] name_length;
	logic       end_of_run;

	modport source (output valid, output result_kind, output name_char, output verdict,
		output name_length, output end_of_run, input ready);
	modport sink   (input valid, input result_kind, input name_char, input verdict,
		input name_length, input end_of_run, output ready);
endinterface
`default_nettype wire

// File: sv/dns_query_name_extractor.sv
// DNS query name extractor: header check, first question name walk and verdict.
//
// Usage: packet bytes enter on pkt, one per transfer, last_byte on the final
// byte. Results leave on res: a lower-cased name character or dot (result_kind
// 0), and on the last byte a verdict with the name length (result_kind 1,
// end_of_run 1). One byte yields at most a character and a verdict.
// A result is registered in the result queue before it is offered on res.
// Throughput: one byte per cycle while results are taken as fast as they
// come; a byte that yields two results pushes both at once, the extra one
// absorbed by a four-entry result queue.
// pkt.ready is high while the queue has room for two results, so a stalled
// receiver holds results in the queue and then stops byte transfers.
// Reset empties the queue and returns the parser to the header phase;
// the parser also returns there after every last byte.
// Bytes beyond the first 512 of a packet are not parsed.
`default_nettype none
module dns_query_name_extractor (
	input  wire           clk,
	input  wire           arst_n,
	dnq_byte_if.sink      pkt,
	dnq_result_if.source  res
);

	logic [dnq_pkg::POS_W-1:0] pos_q, pos_d;
	dnq_pkg::phase_t           phase_q, phase_d;
	logic [5:0]                left_q, left_d;
	logic [8:0]                chars_q, chars_d;
	logic [2:0]                err_q, err_d;
	logic [7:0]                cnthi_q, cnthi_d;
	logic                      seen_q, seen_d;

	logic       accept;
	logic       ch_valid;
	logic [7:0] ch_val;
	logic [7:0] b;
	logic [2:0] verdict_v;

	dnq_pkg::result_t                fifo_q [dnq_pkg::FIFO_DEPTH];
	logic [dnq_pkg::FIFO_AW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [dnq_pkg::FIFO_CW-1:0]     count_q;
	dnq_pkg::result_t                ent0, ent1;
	logic [1:0]                      n_push;
	logic                            pop;

	assign b      = pkt.data_byte;
	assign accept = pkt.valid && pkt.ready;

	always_comb begin
		pos_d    = pos_q;
		phase_d  = phase_q;
		left_d   = left_q;
		err_d    = err_q;
		cnthi_d  = cnthi_q;
		seen_d   = seen_q;
		ch_valid = 1'b0;
		ch_val   = dnq_pkg::DOT_CHAR;
		if (pos_q < dnq_pkg::BUF_LIMIT) begin
			pos_d = pos_q + 1'b1;
			case (phase_q)
				dnq_pkg::PH_HEADER: begin
					if (pos_q == dnq_pkg::POS_FLAGS && b[7:3] != 5'd0 && err_d == dnq_pkg::V_OK)
						err_d = dnq_pkg::V_NOTSTD;
					if (pos_q == dnq_pkg::POS_QDHI)
						cnthi_d = b;
					if (pos_q == dnq_pkg::POS_QDLO && cnthi_q == 8'd0 && b == 8'd0 &&
						err_d == dnq_pkg::V_OK)
						err_d = dnq_pkg::V_NOQ;
					if (pos_q == dnq_pkg::POS_HLAST)
						phase_d = (err_d != dnq_pkg::V_OK) ? dnq_pkg::PH_DONE : dnq_pkg::PH_LENGTH;
				end
				dnq_pkg::PH_LENGTH: begin
					if (b == 8'd0) begin
						phase_d = dnq_pkg::PH_DONE;
					end else if (b > dnq_pkg::MAX_LABEL) begin
						if (err_d == dnq_pkg::V_OK)
							err_d = dnq_pkg::V_BADLABEL;
						phase_d = dnq_pkg::PH_DONE;
					end else begin
						ch_valid = seen_q && !pkt.last_byte;
						ch_val   = dnq_pkg::DOT_CHAR;
						seen_d   = 1'b1;
						left_d   = b[5:0];
						phase_d  = dnq_pkg::PH_LABEL;
					end
				end
				dnq_pkg::PH_LABEL: begin
					ch_valid = 1'b1;
					ch_val   = (b inside {[8'd65:8'd90]}) ? (b + 8'd32) : b;
					if (left_q != 6'd0)
						left_d = left_q - 6'd1;
					if (left_d == 6'd0)
						phase_d = dnq_pkg::PH_LENGTH;
				end
				default: begin
				end
			endcase
		end
		chars_d = (ch_valid && chars_q != dnq_pkg::LEN_MAX) ? chars_q + 9'd1 : chars_q;

		if (pos_d < dnq_pkg::HDR_BYTES)
			verdict_v = dnq_pkg::V_SHORT;
		else if (err_d != dnq_pkg::V_OK)
			verdict_v = err_d;
		else if (phase_d == dnq_pkg::PH_LABEL && left_d != 6'd0)
			verdict_v = dnq_pkg::V_BADLABEL;
		else if (chars_d == 9'd0)
			verdict_v = dnq_pkg::V_EMPTY;
		else
			verdict_v = dnq_pkg::V_OK;
	end

	always_comb begin
		dnq_pkg::result_t c_res, v_res;
		c_res.result_kind = dnq_pkg::RK_CHAR;
		c_res.name_char   = ch_val;
		c_res.verdict     = dnq_pkg::V_OK;
		c_res.name_length = 9'd0;
		c_res.end_of_run  = 1'b0;
		v_res.result_kind = dnq_pkg::RK_VERDICT;
		v_res.name_char   = 8'd0;
		v_res.verdict     = verdict_v;
		v_res.name_length = chars_d;
		v_res.end_of_run  = 1'b1;
		ent0   = ch_valid ? c_res : v_res;
		ent1   = v_res;
		n_push = accept ? ({1'b0, ch_valid} + {1'b0, pkt.last_byte}) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			phase_q <= dnq_pkg::PH_HEADER;
			left_q  <= '0;
			chars_q <= '0;
			err_q   <= dnq_pkg::V_OK;
			cnthi_q <= '0;
			seen_q  <= 1'b0;
		end else if (accept) begin
			if (pkt.last_byte) begin
				pos_q   <= '0;
				phase_q <= dnq_pkg::PH_HEADER;
				left_q  <= '0;
				chars_q <= '0;
				err_q   <= dnq_pkg::V_OK;
				cnthi_q <= '0;
				seen_q  <= 1'b0;
			end else begin
				pos_q   <= pos_d;
				phase_q <= phase_d;
				left_q  <= left_d;
				chars_q <= chars_d;
				err_q   <= err_d;
				cnthi_q <= cnthi_d;
				seen_q  <= seen_d;
			end
		end
	end

	// Result queue
	assign pop       = res.valid && res.ready;
	assign pkt.ready = (count_q <= dnq_pkg::FIFO_CW'(dnq_pkg::FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (n_push != 2'd0)
			fifo_q[wr_ptr_q] <= ent0;
		if (n_push == 2'd2)
			fifo_q[wr_ptr_q + 1'b1] <= ent1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + dnq_pkg::FIFO_AW'(n_push);
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + dnq_pkg::FIFO_CW'(n_push) - dnq_pkg::FIFO_CW'(pop);
		end
	end

	assign res.valid       = (count_q != '0);
	assign res.result_kind = fifo_q[rd_ptr_q].result_kind;
	assign res.name_char   = fifo_q[rd_ptr_q].name_char;
	assign res.verdict     = fifo_q[rd_ptr_q].verdict;
	assign res.name_length = fifo_q[rd_ptr_q].name_length;
	assign res.end_of_run  = fifo_q[rd_ptr_q].end_of_run;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= dnq_pkg::FIFO_CW'(dnq_pkg::FIFO_DEPTH))
		else $error("result queue overfilled");

	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		accept && pkt.last_byte |=> pos_q == '0 && chars_q == '0 && err_q == dnq_pkg::V_OK)
		else $error("parser state not cleared after last byte");

	a_last_pushes_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		accept && pkt.last_byte |=> count_q != '0)
		else $error("verdict not queued");

endmodule
`default_nettype wire
